// ===== hdl/mesh_edge_extractor_top_defines.svh =====
// Assertion macros shared by the checker of the mesh edge extractor.
`ifndef MESH_EDGE_EXTRACTOR_TOP_DEFINES_SVH
`define MESH_EDGE_EXTRACTOR_TOP_DEFINES_SVH

// Checked only while reset is low.
`define MEE_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mesh edge extractor check failed");

// Checked at every edge, reset included.
`define MEE_CHECK_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mesh edge extractor reset check failed");

`endif

// ===== hdl/mee_pkg.sv =====
`timescale 1ns / 1ps
package mee_pkg;

  localparam int VERTICES   = 4096;
  localparam int MAX_DEGREE = 16;
  localparam int VTX_W      = 12;
  localparam int VIDX_W     = $clog2(VERTICES);
  localparam int SLOT_W     = $clog2(MAX_DEGREE);
  localparam int CNT_W      = $clog2(MAX_DEGREE + 1);

  typedef logic [VTX_W-1:0]  vtx_t;
  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    EDGE_AB,
    EDGE_BC,
    EDGE_CA
  } edge_t;

  typedef struct packed {
    vidx_t               row_u;
    vidx_t               row_w;
    vtx_t                probe;
    logic                store_we;
    vidx_t               wr_row;
    logic [SLOT_W-1:0]   wr_slot;
    vtx_t                wr_vtx;
    logic                cnt_we;
    vidx_t               cnt_addr;
    cnt_t                cnt_data;
  } lists_req_t;

  typedef struct packed {
    logic hit;
    cnt_t cnt_w;
  } lists_rsp_t;

endpackage

// ===== hdl/mee_lists.sv =====
`timescale 1ns / 1ps
module mee_lists import mee_pkg::*; (
  input  logic       clk,
  input  lists_req_t req,
  output lists_rsp_t rsp
);

  vtx_t store [VERTICES][MAX_DEGREE];
  cnt_t cnt_mem [VERTICES];

  vtx_t row_q [MAX_DEGREE];
  cnt_t cnt_u_q;
  cnt_t cnt_w_q;

  always_ff @(posedge clk) begin
    if (req.store_we) begin
      store[req.wr_row][req.wr_slot] <= req.wr_vtx;
    end
    row_q <= store[req.row_u];
  end

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.cnt_addr] <= req.cnt_data;
    end
    cnt_u_q <= cnt_mem[req.row_u];
    cnt_w_q <= cnt_mem[req.row_w];
  end

  // Only slots below the list length take part; the probe is held steady
  // by the caller while the read is outstanding.
  always_comb begin
    rsp.hit = 1'b0;
    for (int i = 0; i < MAX_DEGREE; i++) begin
      if ((CNT_W'(i) < cnt_u_q) && (row_q[i] == req.probe)) begin
        rsp.hit = 1'b1;
      end
    end
    rsp.cnt_w = cnt_w_q;
  end

endmodule

// ===== hdl/mesh_edge_extractor_top.sv =====
`timescale 1ns / 1ps
// Each triangle is accepted in the idle state, then each edge takes a list read
// and then a compare and write back, and a flush state releases the final word.
// The last word of a triangle leaves the pending slot in the flush state.
// A held result word stalls the edge sequencer, never the word already waiting.
// After reset the per-vertex list lengths are cleared one vertex per cycle,
// over all VERTICES entries, with in_ready low; control registers reset synchronously.
module mesh_edge_extractor_top import mee_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  vtx_t corner_a,
  input  vtx_t corner_b,
  input  vtx_t corner_c,
  output logic out_valid,
  input  logic out_ready,
  output vtx_t edge_start,
  output vtx_t edge_end,
  output logic last_edge,
  output logic list_overflow
);

  state_t state, state_next;
  edge_t  k;
  vidx_t  clr_idx;
  vtx_t   ca, cb, cc;

  logic pend_valid;
  vtx_t pend_start, pend_end;
  logic pend_over;

  vtx_t u, w;
  logic u_ok, w_ok, emit, over, out_free, push_mid, push_last, check_done;

  lists_req_t req;
  lists_rsp_t rsp;

  mee_lists u_lists (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    unique case (k)
      EDGE_AB: begin
        u = ca;
        w = cb;
      end
      EDGE_BC: begin
        u = cb;
        w = cc;
      end
      default: begin
        u = cc;
        w = ca;
      end
    endcase
  end

  assign u_ok     = 32'(u) < 32'(VERTICES);
  assign w_ok     = 32'(w) < 32'(VERTICES);
  assign emit     = !(rsp.hit && u_ok);
  assign over     = !w_ok || (rsp.cnt_w >= CNT_W'(MAX_DEGREE));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // An emitted edge waits in the pending slot until the next emission or the
  // end of the triangle tells whether it is the last one.
  assign push_mid   = (state == S_CHECK) && emit && pend_valid && out_free;
  assign push_last  = (state == S_FLUSH) && pend_valid && out_free;
  assign check_done = (state == S_CHECK) && !(emit && pend_valid && !out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req          = '0;
    req.row_u    = VIDX_W'(u);
    req.row_w    = VIDX_W'(w);
    req.probe    = w;
    unique case (state)
      S_CLEAR: begin
        req.cnt_we   = 1'b1;
        req.cnt_addr = clr_idx;
        req.cnt_data = '0;
        if (clr_idx == VIDX_W'(VERTICES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (check_done) begin
          if (emit && !over) begin
            req.store_we = 1'b1;
            req.wr_row   = VIDX_W'(w);
            req.wr_slot  = rsp.cnt_w[SLOT_W-1:0];
            req.wr_vtx   = u;
            req.cnt_we   = 1'b1;
            req.cnt_addr = VIDX_W'(w);
            req.cnt_data = rsp.cnt_w + CNT_W'(1);
          end
          state_next = (k == EDGE_CA) ? S_FLUSH : S_READ;
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == S_CLEAR) begin
      clr_idx <= clr_idx + VIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= EDGE_AB;
    end else if (in_valid && in_ready) begin
      k <= EDGE_AB;
    end else if (check_done) begin
      unique case (k)
        EDGE_AB: k <= EDGE_BC;
        EDGE_BC: k <= EDGE_CA;
        default: k <= EDGE_CA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ca <= corner_a;
      cb <= corner_b;
      cc <= corner_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (check_done && emit) begin
      pend_valid <= 1'b1;
    end else if (push_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (check_done && emit) begin
      pend_start <= u;
      pend_end   <= w;
      pend_over  <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      edge_start    <= pend_start;
      edge_end      <= pend_end;
      list_overflow <= pend_over;
      last_edge     <= push_last;
    end
  end

endmodule

// ===== hdl/mee_checker.sv =====
`timescale 1ns / 1ps
`include "mesh_edge_extractor_top_defines.svh"
module mee_checker import mee_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input vtx_t edge_start,
  input vtx_t edge_end,
  input logic last_edge,
  input logic list_overflow
);

  // A waiting result word must not change or vanish.
  `MEE_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(edge_start) && $stable(edge_end) && $stable(last_edge) && $stable(list_overflow))

  // Triangles are worked one at a time, so a new word is never taken twice in a row.
  `MEE_CHECK(a_in_single, in_valid && in_ready |=> !in_ready)

  // Reset starts the clearing sweep, during which nothing is taken or shown.
  `MEE_CHECK_RST(a_rst_clear, rst |=> !in_ready && !out_valid)

endmodule

bind mesh_edge_extractor_top mee_checker u_mee_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mee_pkg::*;

  localparam int CORNERS      = 3;
  localparam int RANDOM_TRIS  = 124;
  localparam int PHASES       = 4;
  localparam int POOL_SPAN    = 12;
  localparam int HISTORY      = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HUB          = 100;

  typedef struct packed {
    vtx_t from_v;
    vtx_t to_v;
    logic last;
    logic over;
  } edge_word_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  // A row with n_typed below zero is checked against the predictor only.
  typedef struct {
    tri_t       corners;
    int         n_typed;
    edge_word_t typed [CORNERS];
  } tri_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  vtx_t corner_a = '0;
  vtx_t corner_b = '0;
  vtx_t corner_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vtx_t edge_start;
  vtx_t edge_end;
  logic last_edge;
  logic list_overflow;

  mesh_edge_extractor_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .corner_a(corner_a),
    .corner_b(corner_b),
    .corner_c(corner_c),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .edge_start(edge_start),
    .edge_end(edge_end),
    .last_edge(last_edge),
    .list_overflow(list_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor state: per-vertex predecessor lists and their lengths.
  vtx_t        pred_list [VERTICES][MAX_DEGREE];
  int unsigned pred_len  [VERTICES];

  edge_word_t fresh_edges [$];
  edge_word_t edge_queue  [$];
  tri_row_t   directed_rows [$];
  tri_t       recent_tris [$];

  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned cycle_count = 0;
  vtx_t pool_base = '0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bit already_linked(vtx_t u, vtx_t w);
    for (int i = 0; i < pred_len[u] && i < MAX_DEGREE; i++)
      if (pred_list[u][i] == w) return 1'b1;
    return 1'b0;
  endfunction

  // Walks the three directed edges of a triangle in order, updating the lists
  // as it goes, and leaves the words the block should emit in fresh_edges.
  function automatic void trace_triangle(tri_t t);
    vtx_t       corner [CORNERS];
    vtx_t       u;
    vtx_t       w;
    edge_word_t word;
    corner[0] = t.a;
    corner[1] = t.b;
    corner[2] = t.c;
    fresh_edges.delete();
    for (int k = 0; k < CORNERS; k++) begin
      u = corner[k];
      w = corner[(k + 1) % CORNERS];
      if (!already_linked(u, w)) begin
        word.from_v = u;
        word.to_v   = w;
        word.last   = 1'b0;
        word.over   = (pred_len[w] >= MAX_DEGREE);
        if (!word.over) begin
          pred_list[w][pred_len[w]] = u;
          pred_len[w]++;
        end
        fresh_edges.insert(fresh_edges.size(), word);
      end
    end
    if (fresh_edges.size() > 0)
      fresh_edges[fresh_edges.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_row(vtx_t a, vtx_t b, vtx_t c, int n_typed = -1,
                                  edge_word_t w0 = '0, edge_word_t w1 = '0,
                                  edge_word_t w2 = '0);
    tri_row_t row;
    row.corners  = '{a, b, c};
    row.n_typed  = n_typed;
    row.typed[0] = w0;
    row.typed[1] = w1;
    row.typed[2] = w2;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic send_triangle(input tri_row_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    corner_a <= row.corners.a;
    corner_b <= row.corners.b;
    corner_c <= row.corners.c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trace_triangle(row.corners);
    if (row.n_typed >= 0) begin
      for (int i = 0; i < row.n_typed; i++)
        edge_queue.insert(edge_queue.size(), row.typed[i]);
    end else begin
      foreach (fresh_edges[i]) edge_queue.insert(edge_queue.size(), fresh_edges[i]);
    end
  endtask

  function automatic vtx_t pool_vertex();
    return pool_base + vtx_t'($urandom_range(POOL_SPAN - 1));
  endfunction

  // Mostly small-pool meshes, so lists fill and reverse edges get found.
  function automatic tri_t random_triangle();
    tri_t t;
    tri_t old;
    vtx_t v;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 45 || recent_tris.size() == 0) begin
      t = '{pool_vertex(), pool_vertex(), pool_vertex()};
    end else if (pick < 70) begin
      old = recent_tris[$urandom_range(recent_tris.size() - 1)];
      case ($urandom_range(2))
        0: t = '{old.c, old.b, old.a};
        1: t = '{old.b, old.c, old.a};
        default: t = '{old.b, old.a, pool_vertex()};
      endcase
    end else if (pick < 85) begin
      t = '{vtx_t'($urandom_range(4095)), vtx_t'($urandom_range(4095)),
            vtx_t'($urandom_range(4095))};
    end else begin
      v = pool_vertex();
      if ($urandom_range(1) != 0)
        t = '{v, v, v};
      else
        t = '{v, v, pool_vertex()};
    end
    recent_tris.insert(recent_tris.size(), t);
    if (recent_tris.size() > HISTORY) void'(recent_tris.pop_front());
    return t;
  endfunction

  always @(posedge clk) begin : check_words
    edge_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (edge_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d->%0d", edge_start, edge_end));
      end else begin
        want = edge_queue.pop_front();
        if (edge_start !== want.from_v)
          report_mismatch($sformatf("edge_start %0d, want %0d", edge_start, want.from_v));
        if (edge_end !== want.to_v)
          report_mismatch($sformatf("edge_end %0d, want %0d", edge_end, want.to_v));
        if (last_edge !== want.last)
          report_mismatch($sformatf("last_edge %b, want %b", last_edge, want.last));
        if (list_overflow !== want.over)
          report_mismatch($sformatf("list_overflow %b, want %b", list_overflow, want.over));
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    tri_row_t row;
    foreach (pred_len[i]) pred_len[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_row(12'd0, 12'd1, 12'd2, 3, '{12'd0, 12'd1, 1'b0, 1'b0},
            '{12'd1, 12'd2, 1'b0, 1'b0}, '{12'd2, 12'd0, 1'b1, 1'b0});
    // Every edge here is the reverse of one already emitted.
    add_row(12'd2, 12'd1, 12'd0, 0);
    add_row(12'd0, 12'd1, 12'd2);
    add_row(12'd1, 12'd2, 12'd0);
    add_row(12'd4095, 12'd4095, 12'd4095, 1, '{12'd4095, 12'd4095, 1'b1, 1'b0});
    add_row(12'd4095, 12'd4095, 12'd4095, 0);
    add_row(12'hAAA, 12'h555, 12'hFFF);
    add_row(12'h555, 12'hAAA, 12'h000);
    add_row(12'd0, 12'd4095, 12'd0);
    // Fill the list of the hub vertex, then run past its end.
    for (int k = 1; k <= MAX_DEGREE + 1; k++)
      add_row(vtx_t'(k), vtx_t'(HUB), vtx_t'(HUB));

    foreach (directed_rows[i]) send_triangle(directed_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      pool_base = (p % 2 == 0) ? vtx_t'(0) : vtx_t'(4096 - 16);
      recent_tris.delete();
      for (int i = 0; i < RANDOM_TRIS / PHASES; i++) begin
        row.corners = random_triangle();
        row.n_typed = -1;
        send_triangle(row);
      end
    end
    in_valid <= 1'b0;

    while (edge_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mee_pkg.sv
hdl/mee_lists.sv
hdl/mesh_edge_extractor_top.sv
hdl/mee_checker.sv
verif/testbench.sv
